// File: sv/iss_pkg.sv
// shared types and constants for the indexed sequence store
`timescale 1ns / 1ps

package iss_pkg;

	localparam int CAPACITY = 256;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = 32;
	localparam int PW = 16;

	typedef enum logic [2:0] {
		REQ_READ    = 3'd0,
		REQ_INS_HD  = 3'd1,
		REQ_INS_TL  = 3'd2,
		REQ_INS_AT  = 3'd3,
		REQ_DELETE  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_DONE,
		ST_MV_RD,
		ST_MV_WR,
		ST_WR_NEW
	} state_t;

endpackage

// File: sv/indexed_sequence_store.sv
// Ordered store of up to 256 signed words; a rejected request or a delete of the last entry
// finishes from the idle state, a read passes through a read-done state, an insert ends in a
// write of the new entry, and inserts and deletes first move each entry that has to shift, each
// move a read and then a write through the single-port entry memory under one address counter
// (the longest case is an insert at the head of 255 entries); busy is high while a move, a read
// or the write of a new entry is under way, and done is high for exactly one cycle with data_out,
// status and item_count valid, with no way for the receiver to hold it off.
`timescale 1ns / 1ps

module indexed_sequence_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    req_type,
	input  logic [iss_pkg::PW-1:0]        position,
	input  logic signed [iss_pkg::DW-1:0] data_in,
	output logic                          done,
	output logic signed [iss_pkg::DW-1:0] data_out,
	output logic [1:0]                    status,
	output logic [iss_pkg::CW-1:0]        item_count
);

	iss_pkg::state_t state_q, state_d;

	logic [iss_pkg::DW-1:0] mem [iss_pkg::CAPACITY];
	logic [iss_pkg::DW-1:0] rd_data_q;

	logic [iss_pkg::CW-1:0] count_q, count_d;
	logic [iss_pkg::AW-1:0] cur_q, cur_d;
	logic [iss_pkg::AW-1:0] at_q, at_d;
	logic [iss_pkg::DW-1:0] val_q;
	logic                   up_q, up_d;

	logic                   accept;
	logic                   mem_rd, mem_wr;
	logic [iss_pkg::AW-1:0] rd_addr, wr_addr;
	logic [iss_pkg::DW-1:0] wr_data;
	logic                   fin;
	iss_pkg::status_t       fin_status;
	logic [iss_pkg::DW-1:0] fin_data;

	logic                   done_q;
	logic [iss_pkg::DW-1:0] data_q;
	iss_pkg::status_t       status_q;

	logic [iss_pkg::PW-1:0] count_ext;
	logic [iss_pkg::AW-1:0] count_lo;
	logic [iss_pkg::AW-1:0] ins_at;

	assign busy       = (state_q != iss_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign count_ext  = iss_pkg::PW'(count_q);
	assign count_lo   = count_q[iss_pkg::AW-1:0];
	assign done       = done_q;
	assign data_out   = data_q;
	assign status     = status_q;
	assign item_count = count_q;

	always_comb begin
		if (req_type == iss_pkg::REQ_INS_HD) begin
			ins_at = '0;
		end else if (req_type == iss_pkg::REQ_INS_TL) begin
			ins_at = count_lo;
		end else begin
			ins_at = position[iss_pkg::AW-1:0];
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		cur_d      = cur_q;
		at_d       = at_q;
		up_d       = up_q;
		mem_rd     = 1'b0;
		mem_wr     = 1'b0;
		rd_addr    = cur_q;
		wr_addr    = cur_q;
		wr_data    = rd_data_q;
		fin        = 1'b0;
		fin_status = iss_pkg::STAT_DONE;
		fin_data   = '0;
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (accept) begin
					case (req_type)
						iss_pkg::REQ_READ: begin
							if (position < count_ext) begin
								mem_rd  = 1'b1;
								rd_addr = position[iss_pkg::AW-1:0];
								state_d = iss_pkg::ST_RD_DONE;
							end else begin
								fin        = 1'b1;
								fin_status = iss_pkg::STAT_RANGE;
								fin_data   = '1;
							end
						end
						iss_pkg::REQ_INS_HD, iss_pkg::REQ_INS_TL, iss_pkg::REQ_INS_AT: begin
							if (req_type == iss_pkg::REQ_INS_AT && position > count_ext) begin
								fin        = 1'b1;
								fin_status = iss_pkg::STAT_RANGE;
							end else if (count_q == iss_pkg::CW'(iss_pkg::CAPACITY)) begin
								fin        = 1'b1;
								fin_status = iss_pkg::STAT_FULL;
							end else begin
								at_d = ins_at;
								up_d = 1'b1;
								if (ins_at == count_lo) begin
									state_d = iss_pkg::ST_WR_NEW;
								end else begin
									// walk from the last entry down to the insert point
									cur_d   = count_lo - iss_pkg::AW'(1);
									state_d = iss_pkg::ST_MV_RD;
								end
							end
						end
						iss_pkg::REQ_DELETE: begin
							if (position >= count_ext) begin
								fin        = 1'b1;
								fin_status = iss_pkg::STAT_RANGE;
							end else begin
								at_d = position[iss_pkg::AW-1:0];
								cur_d = position[iss_pkg::AW-1:0];
								up_d = 1'b0;
								if (iss_pkg::CW'(position[iss_pkg::AW-1:0]) + iss_pkg::CW'(1)
									== count_q) begin
									// last entry goes, nothing to move
									fin     = 1'b1;
									count_d = count_q - iss_pkg::CW'(1);
								end else begin
									state_d = iss_pkg::ST_MV_RD;
								end
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			iss_pkg::ST_RD_DONE: begin
				fin      = 1'b1;
				fin_data = rd_data_q;
				state_d  = iss_pkg::ST_IDLE;
			end
			iss_pkg::ST_MV_RD: begin
				mem_rd  = 1'b1;
				rd_addr = up_q ? cur_q : cur_q + iss_pkg::AW'(1);
				state_d = iss_pkg::ST_MV_WR;
			end
			iss_pkg::ST_MV_WR: begin
				mem_wr  = 1'b1;
				wr_addr = up_q ? cur_q + iss_pkg::AW'(1) : cur_q;
				wr_data = rd_data_q;
				if (up_q) begin
					if (cur_q == at_q) begin
						state_d = iss_pkg::ST_WR_NEW;
					end else begin
						cur_d   = cur_q - iss_pkg::AW'(1);
						state_d = iss_pkg::ST_MV_RD;
					end
				end else begin
					if (iss_pkg::CW'(cur_q) + iss_pkg::CW'(2) == count_q) begin
						fin     = 1'b1;
						count_d = count_q - iss_pkg::CW'(1);
						state_d = iss_pkg::ST_IDLE;
					end else begin
						cur_d   = cur_q + iss_pkg::AW'(1);
						state_d = iss_pkg::ST_MV_RD;
					end
				end
			end
			iss_pkg::ST_WR_NEW: begin
				mem_wr  = 1'b1;
				wr_addr = at_q;
				wr_data = val_q;
				fin     = 1'b1;
				count_d = count_q + iss_pkg::CW'(1);
				state_d = iss_pkg::ST_IDLE;
			end
			default: begin
				state_d = iss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iss_pkg::ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= iss_pkg::STAT_DONE;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (fin) begin
				status_q <= fin_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		at_q  <= at_d;
		up_q  <= up_d;
		if (accept) begin
			val_q <= data_in;
		end
		if (fin) begin
			data_q <= fin_data;
		end
	end

	// entry memory, one access port used for either a read or a write
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iss_pkg::CW'(iss_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(accept) || $past(busy)))
		else $error("result word without a request");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == iss_pkg::STAT_FULL) |-> count_q == iss_pkg::CW'(iss_pkg::CAPACITY))
		else $error("full reported while not full");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_wr)
		else $error("memory written while idle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |=> ($stable(count_q) || done_q))
		else $error("entry count changed without a result");

endmodule

// File: tb/tb_indexed_sequence_store.sv
// self-checking testbench for the indexed sequence store
`timescale 1ns / 1ps

module tb_indexed_sequence_store;

	localparam int CLK_PERIOD  = 12;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int END_WAIT    = 600;

	// request kinds 5 to 7 are unused codes, so the kind is kept as raw bits
	typedef struct {
		logic [2:0]                    kind;
		logic [iss_pkg::PW-1:0]        pos;
		logic signed [iss_pkg::DW-1:0] value;
	} request_t;

	typedef struct {
		logic signed [iss_pkg::DW-1:0] value;
		iss_pkg::status_t              stat;
		logic [iss_pkg::CW-1:0]        count;
	} outcome_t;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [2:0]                    req_type = '0;
	logic [iss_pkg::PW-1:0]        position = '0;
	logic signed [iss_pkg::DW-1:0] data_in = '0;
	logic                          done;
	logic signed [iss_pkg::DW-1:0] data_out;
	logic [1:0]                    status;
	logic [iss_pkg::CW-1:0]        item_count;

	request_t                      pending_requests[$];
	outcome_t                      expected_outcomes[$];
	logic signed [iss_pkg::DW-1:0] shadow_entries[iss_pkg::CAPACITY];
	int                            shadow_count = 0;
	int                            error_count = 0;
	int                            cycle_count = 0;
	int                            burst_left = 1;
	int                            gap_left = 0;
	bit                            word_taken;
	request_t                      taken_word;
	outcome_t                      oldest;

	indexed_sequence_store i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.data_in    (data_in),
		.done       (done),
		.data_out   (data_out),
		.status     (status),
		.item_count (item_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// shifts the shadow sequence just as the block should and records the outcome
	function automatic void predict_outcome(input request_t rq);
		outcome_t res;
		int       at;
		int       k;
		res.value = '0;
		res.stat  = iss_pkg::STAT_DONE;
		case (rq.kind)
			iss_pkg::REQ_READ: begin
				if (int'(rq.pos) < shadow_count) begin
					res.value = shadow_entries[rq.pos];
				end else begin
					res.value = -1;
					res.stat  = iss_pkg::STAT_RANGE;
				end
			end
			iss_pkg::REQ_INS_HD, iss_pkg::REQ_INS_TL, iss_pkg::REQ_INS_AT: begin
				if (rq.kind == iss_pkg::REQ_INS_HD)
					at = 0;
				else if (rq.kind == iss_pkg::REQ_INS_TL)
					at = shadow_count;
				else
					at = int'(rq.pos);
				// range is checked ahead of full
				if (at > shadow_count) begin
					res.stat = iss_pkg::STAT_RANGE;
				end else if (shadow_count >= iss_pkg::CAPACITY) begin
					res.stat = iss_pkg::STAT_FULL;
				end else begin
					for (k = shadow_count; k > at; k--)
						shadow_entries[k] = shadow_entries[k - 1];
					shadow_entries[at] = rq.value;
					shadow_count++;
				end
			end
			iss_pkg::REQ_DELETE: begin
				if (int'(rq.pos) >= shadow_count) begin
					res.stat = iss_pkg::STAT_RANGE;
				end else begin
					for (k = int'(rq.pos); k + 1 < shadow_count; k++)
						shadow_entries[k] = shadow_entries[k + 1];
					shadow_count--;
				end
			end
			default: ;
		endcase
		res.count = shadow_count[iss_pkg::CW-1:0];
		expected_outcomes.push_back(res);
	endfunction

	function automatic request_t random_request(input mix_t mix);
		request_t rq;
		int       roll;
		int       span;
		int       w_rd;
		int       w_hd;
		int       w_tl;
		int       w_at;
		int       w_del;
		case (mix)
			MIX_FILL: begin
				w_rd = 8; w_hd = 15; w_tl = 40; w_at = 27; w_del = 5;
			end
			MIX_DRAIN: begin
				w_rd = 7; w_hd = 2; w_tl = 2; w_at = 2; w_del = 83;
			end
			default: begin
				w_rd = 25; w_hd = 10; w_tl = 12; w_at = 15; w_del = 30;
			end
		endcase
		roll = $urandom_range(99, 0);
		if (roll < w_rd)
			rq.kind = iss_pkg::REQ_READ;
		else if (roll < w_rd + w_hd)
			rq.kind = iss_pkg::REQ_INS_HD;
		else if (roll < w_rd + w_hd + w_tl)
			rq.kind = iss_pkg::REQ_INS_TL;
		else if (roll < w_rd + w_hd + w_tl + w_at)
			rq.kind = iss_pkg::REQ_INS_AT;
		else if (roll < w_rd + w_hd + w_tl + w_at + w_del)
			rq.kind = iss_pkg::REQ_DELETE;
		else
			rq.kind = 3'($urandom_range(7, 5));

		// insert at index may also land on count itself
		span = (rq.kind == iss_pkg::REQ_INS_AT) ? shadow_count : shadow_count - 1;
		roll = $urandom_range(99, 0);
		if (roll < 78)
			rq.pos = (span < 0) ? '0 : iss_pkg::PW'($urandom_range(span, 0));
		else if (roll < 86)
			rq.pos = iss_pkg::PW'(shadow_count);
		else if (roll < 90)
			rq.pos = iss_pkg::PW'(shadow_count + 1);
		else if (roll < 95)
			rq.pos = '0;
		else
			rq.pos = iss_pkg::PW'($urandom());

		roll = $urandom_range(99, 0);
		if (roll < 80)
			rq.value = $urandom();
		else if (roll < 85)
			rq.value = 32'h7FFF_FFFF;
		else if (roll < 90)
			rq.value = 32'h8000_0000;
		else if (roll < 95)
			rq.value = -1;
		else
			rq.value = '0;
		return rq;
	endfunction

	task automatic queue_request(input logic [2:0] kind, input int pos,
			input logic signed [iss_pkg::DW-1:0] value);
		request_t rq;
		rq.kind  = kind;
		rq.pos   = iss_pkg::PW'(pos);
		rq.value = value;
		pending_requests.push_back(rq);
	endtask

	// keeps the queue shallow so that positions follow the current count
	task automatic queue_random(input mix_t mix);
		while (pending_requests.size() >= 2)
			@(negedge clk);
		pending_requests.push_back(random_request(mix));
	endtask

	task automatic wait_until_settled;
		while (pending_requests.size() != 0 || expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// driver: a word goes in at an edge with start high and busy low
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			word_taken = start && !busy;
			if (word_taken) begin
				taken_word = pending_requests.pop_front();
				predict_outcome(taken_word);
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(16, 1);
					gap_left   = ($urandom_range(99, 0) < 30) ? 0 : $urandom_range(10, 1);
				end
			end else if (!start && gap_left > 0) begin
				gap_left--;
			end
			if (gap_left == 0 && pending_requests.size() > 0) begin
				start    <= 1'b1;
				req_type <= pending_requests[0].kind;
				position <= pending_requests[0].pos;
				data_in  <= pending_requests[0].value;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: done cannot be held off, so every strobe is taken at once
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, data_out %0d",
					data_out));
			end else begin
				oldest = expected_outcomes.pop_front();
				if (data_out !== oldest.value)
					report_mismatch($sformatf("data_out %0d, expected %0d",
						data_out, oldest.value));
				if (status !== oldest.stat)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, oldest.stat));
				if (item_count !== oldest.count)
					report_mismatch($sformatf("item_count %0d, expected %0d",
						item_count, oldest.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_indexed_sequence_store: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store: everything but a plain insert is rejected
		queue_request(iss_pkg::REQ_READ,   0,      32'sd5);
		queue_request(iss_pkg::REQ_DELETE, 0,      32'sd5);
		queue_request(iss_pkg::REQ_INS_AT, 1,      32'sd7);
		queue_request(iss_pkg::REQ_INS_AT, 0,      32'h7FFF_FFFF);
		// head and tail ignore the position
		queue_request(iss_pkg::REQ_INS_HD, 16'hFFFF, 32'h8000_0000);
		queue_request(iss_pkg::REQ_INS_TL, 16'hFFFF, -1);
		queue_request(iss_pkg::REQ_INS_AT, 3,      32'sd0);
		queue_request(iss_pkg::REQ_INS_AT, 1,      32'h5A5A_5A5A);
		queue_request(iss_pkg::REQ_READ,   0,      32'h1234_5678);
		queue_request(iss_pkg::REQ_READ,   4,      32'sd0);
		queue_request(iss_pkg::REQ_READ,   5,      32'sd0);
		queue_request(iss_pkg::REQ_READ,   16'hFFFF, 32'sd0);
		queue_request(3'd5,                16'hAAAA, 32'h5555_5555);
		queue_request(3'd6,                16'h5555, 32'hAAAA_AAAA);
		queue_request(3'd7,                16'hFFFF, -1);
		queue_request(iss_pkg::REQ_DELETE, 4,      32'sd0);
		queue_request(iss_pkg::REQ_DELETE, 0,      32'sd0);
		queue_request(iss_pkg::REQ_DELETE, 16'hFFFF, 32'sd0);
		queue_request(iss_pkg::REQ_INS_AT, 16'hFFFF, 32'sd9);
		queue_request(iss_pkg::REQ_READ,   1,      32'sd0);
		queue_request(iss_pkg::REQ_READ,   2,      32'sd0);
		queue_request(iss_pkg::REQ_DELETE, 1,      32'sd0);
		queue_request(iss_pkg::REQ_READ,   0,      32'sd0);
		queue_request(iss_pkg::REQ_READ,   1,      32'sd0);
		wait_until_settled();

		// fill to capacity, then keep pushing so that full is seen
		while (shadow_count < iss_pkg::CAPACITY)
			queue_random(MIX_FILL);
		repeat (12) queue_random(MIX_FILL);
		wait_until_settled();

		repeat (120) queue_random(MIX_BALANCED);
		wait_until_settled();

		while (shadow_count > 0)
			queue_random(MIX_DRAIN);
		repeat (10) queue_random(MIX_DRAIN);
		repeat (40) queue_random(MIX_BALANCED);

		wait_until_settled();
		// room for a stray strobe after the last one
		repeat (END_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("tb_indexed_sequence_store: PASS");
		else
			$display("tb_indexed_sequence_store: FAIL");
		$finish;
	end

endmodule
